### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SOS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is asserted
`define SOS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/sosmet_pkg.sv
// ----------------------------------------------------------------------------
// sosmet_pkg
// Shared widths, register indexes and control types of the SOS Metropolis step.
// ----------------------------------------------------------------------------
package sosmet_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W         = 3;
	localparam int REG_LATTICE_WIDTH = 0;
	localparam int REG_REF_HEIGHT    = 1;
	localparam int REG_THR_FIRST     = 2;
	localparam int THR_CNT           = 6;
	localparam int THR_IDX_W         = 3;

	// register widths
	localparam int LW_W  = 11;
	localparam int REF_W = 7;
	localparam int THR_W = 33;

	// input item fields
	localparam int SITE_W      = 10;
	localparam int DRAW_W      = 32;
	localparam int IN_STEP_BIT = SITE_W;
	localparam int IN_DRAW_LSB = SITE_W + 1;
	localparam int IN_TDATA_W  = 48;

	// result item fields
	localparam int OUT_H_W     = 8;
	localparam int OP_W        = 18;
	localparam int SUM_W       = 64;
	localparam int SQ_W        = 63;
	localparam int PROD_W      = 2 * OP_W;
	localparam int OUT_USED_W  = 1 + OUT_H_W + OP_W + SUM_W + SQ_W;
	localparam int OUT_TDATA_W = 160;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

	// sequencer to accumulator unit
	typedef struct packed {
		logic clr;     // reinit: zero all three accumulators
		logic apply;   // accepted move: subtract field change
		logic f_pos;   // field change is +1
		logic square;  // register square of order parameter
		logic add;     // fold into running sums
	} acc_ctl_t;

endpackage

### hw/rtl/sosmet_height_ram.sv
// ----------------------------------------------------------------------------
// sosmet_height_ram
// Height store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sosmet_height_ram #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10,
	parameter int DATA_W = 9
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/sosmet_accum.sv
// ----------------------------------------------------------------------------
// sosmet_accum
// Order parameter and its saturating running sum and square sum.
// ----------------------------------------------------------------------------
module sosmet_accum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sosmet_pkg::acc_ctl_t                 ctl,
	output logic signed [sosmet_pkg::OP_W-1:0]   order_acc,
	output logic signed [sosmet_pkg::SUM_W-1:0]  order_total,
	output logic        [sosmet_pkg::SQ_W-1:0]   order_squares
);

	localparam int OP_W   = sosmet_pkg::OP_W;
	localparam int SUM_W  = sosmet_pkg::SUM_W;
	localparam int SQ_W   = sosmet_pkg::SQ_W;
	localparam int PROD_W = sosmet_pkg::PROD_W;

	logic signed [OP_W-1:0]  order_acc_q;
	logic signed [SUM_W-1:0] order_total_q;
	logic        [SQ_W-1:0]  order_squares_q;
	logic        [PROD_W-1:0] sq_s1;

	logic signed [OP_W:0]    op_ext;
	logic signed [OP_W:0]    op_wide;
	logic signed [OP_W-1:0]  op_next;
	logic signed [PROD_W-1:0] prod;
	logic signed [SUM_W:0]   tsum;
	logic signed [SUM_W-1:0] total_next;
	logic        [SQ_W:0]    ssum;
	logic        [SQ_W-1:0]  squares_next;

	always_comb begin
		op_ext  = {order_acc_q[OP_W-1], order_acc_q};
		// order parameter moves by minus the field change
		op_wide = ctl.f_pos ? op_ext - (OP_W+1)'(1) : op_ext + (OP_W+1)'(1);
		if (op_wide[OP_W] != op_wide[OP_W-1]) begin
			op_next = op_wide[OP_W] ? {1'b1, {(OP_W-1){1'b0}}} : {1'b0, {(OP_W-1){1'b1}}};
		end else begin
			op_next = op_wide[OP_W-1:0];
		end
	end

	assign prod = order_acc_q * order_acc_q;

	always_comb begin
		tsum = {order_total_q[SUM_W-1], order_total_q} + (SUM_W+1)'(order_acc_q);
		if (tsum[SUM_W] != tsum[SUM_W-1]) begin
			total_next = tsum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			total_next = tsum[SUM_W-1:0];
		end
		ssum = (SQ_W+1)'(order_squares_q) + (SQ_W+1)'(sq_s1);
		squares_next = ssum[SQ_W] ? {SQ_W{1'b1}} : ssum[SQ_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_acc_q     <= '0;
			order_total_q   <= '0;
			order_squares_q <= '0;
		end else if (ctl.clr) begin
			order_acc_q     <= '0;
			order_total_q   <= '0;
			order_squares_q <= '0;
		end else begin
			if (ctl.apply) begin
				order_acc_q <= op_next;
			end
			if (ctl.add) begin
				order_total_q   <= total_next;
				order_squares_q <= squares_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.square) begin
			sq_s1 <= $unsigned(prod);
		end
	end

	assign order_acc     = order_acc_q;
	assign order_total   = order_total_q;
	assign order_squares = order_squares_q;

endmodule

### hw/rtl/sos_interface_metropolis_step.sv
// ----------------------------------------------------------------------------
// sos_interface_metropolis_step
// Metropolis trial-move engine for a periodic 1D solid-on-solid interface.
// ----------------------------------------------------------------------------
// Step item: three reads through the single read port of the height RAM, then
//   decide, square and sum stages; the result is registered in S_DONE, held there
//   while the output is stalled, and no new item is taken before it is registered.
// Reinit and off-ring items: go straight to S_DONE for their result; reinit
//   then runs a sweep over all MAX_SITES entries clearing the RAM valid bits.
// Reset: registers to defaults, accumulators zero, then the same sweep.
module sos_interface_metropolis_step #(
	parameter int MAX_SITES   = 1024,
	parameter int HEIGHT_BITS = 8,
	parameter int RANDOM_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// site[9:0], step_up[10], random_draw[42:11], zero pad
	input  logic [sosmet_pkg::IN_TDATA_W-1:0]   s_tdata,
	// cmd
	input  logic                                s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// accepted[0], site_height[8:1], order_param[26:9], order_sum[90:27],
	// order_square_sum[153:91], zero pad
	output logic [sosmet_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                                cfg_we,
	input  logic [sosmet_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [sosmet_pkg::THR_W-1:0]        cfg_data
);

	`include "assert_macros.svh"

	localparam int HB    = HEIGHT_BITS;
	localparam int AW    = $clog2(MAX_SITES);
	localparam int CW    = ($clog2(MAX_SITES + 1) > sosmet_pkg::LW_W) ?
	                       $clog2(MAX_SITES + 1) : sosmet_pkg::LW_W;
	localparam int DW    = ((HB > sosmet_pkg::REF_W) ? HB : sosmet_pkg::REF_W) + 3;
	localparam int RSH   = sosmet_pkg::DRAW_W - RANDOM_BITS;
	localparam int WORD_W = HB + 1;

	// sequencer states
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RDL   = 4'd2;
	localparam logic [3:0] S_RDR   = 4'd3;
	localparam logic [3:0] S_EVAL  = 4'd4;
	localparam logic [3:0] S_DEC   = 4'd5;
	localparam logic [3:0] S_SQ    = 4'd6;
	localparam logic [3:0] S_ADD   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	localparam logic signed [DW-1:0] ONE_S  = DW'(1);
	localparam logic signed [DW-1:0] HMAX_S = DW'((1 << HB) - 1);

	// configuration
	logic [sosmet_pkg::LW_W-1:0]  lattice_width_q;
	logic [sosmet_pkg::REF_W-1:0] ref_height_q;
	logic [sosmet_pkg::THR_W-1:0] thr_q [sosmet_pkg::THR_CNT];
	logic [sosmet_pkg::THR_IDX_W-1:0] cfg_thr_idx;

	// control
	logic [3:0]    state_q;
	logic [AW-1:0] clr_cnt_q;
	logic          reinit_q;

	// item context
	logic [AW-1:0] site_q;
	logic [AW-1:0] left_q;
	logic [AW-1:0] right_q;
	logic          step_q;
	logic [sosmet_pkg::DRAW_W-1:0] draw_q;
	logic [HB-1:0] hx_q;
	logic [HB-1:0] hl_q;
	logic [HB-1:0] hn_q;
	logic          ok_q;
	logic          fpos_q;
	logic [sosmet_pkg::THR_IDX_W-1:0] tsel_q;
	logic          res_acc_q;
	logic [HB-1:0] res_h_q;

	// result register
	logic                                out_acc_q;
	logic [sosmet_pkg::OUT_H_W-1:0]      out_h_q;
	logic signed [sosmet_pkg::OP_W-1:0]  out_op_q;
	logic signed [sosmet_pkg::SUM_W-1:0] out_sum_q;
	logic [sosmet_pkg::SQ_W-1:0]         out_sq_q;
	logic                                m_tvalid_q;

	// input decode
	logic          s_accept;
	logic          s_cmd;
	logic [sosmet_pkg::SITE_W-1:0] s_site;
	logic          s_step;
	logic [sosmet_pkg::DRAW_W-1:0] s_draw;

	logic [CW-1:0] w_eff;
	logic [CW-1:0] site_ext;
	logic [CW-1:0] site_inc;
	logic          in_ring;
	logic [CW-1:0] left_c;
	logic [CW-1:0] right_c;

	// height arithmetic
	logic signed [DW-1:0] ref_s;
	logic signed [DW-1:0] refc_s;
	logic signed [DW-1:0] upper_s;
	logic [HB-1:0]        refc_h;
	logic [HB-1:0]        hr_h;
	logic signed [DW-1:0] hx_s;
	logic signed [DW-1:0] hl_s;
	logic signed [DW-1:0] hr_s;
	logic signed [DW-1:0] hn_s;
	logic signed [DW-1:0] span_new;
	logic signed [DW-1:0] span_old;
	logic                 ev_ok;
	logic                 ev_fpos;
	logic [1:0]           ev_sos;
	logic [sosmet_pkg::THR_W-1:0] thr_sel;
	logic                 dec_acc;
	logic                 out_free;
	logic                 res_h_in_range;

	// memory ports
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	sosmet_pkg::acc_ctl_t acc_ctl;
	logic signed [sosmet_pkg::OP_W-1:0]  order_acc;
	logic signed [sosmet_pkg::SUM_W-1:0] order_total;
	logic [sosmet_pkg::SQ_W-1:0]         order_squares;

	function automatic logic signed [DW-1:0] absd(input logic signed [DW-1:0] v);
		return (v < 0) ? -v : v;
	endfunction

	// a cleared entry reads as the clamped reference height
	function automatic logic [HB-1:0] hval(input logic [WORD_W-1:0] w, input logic [HB-1:0] r);
		return w[HB] ? w[HB-1:0] : r;
	endfunction

	assign s_cmd    = s_tuser;
	assign s_site   = s_tdata[sosmet_pkg::SITE_W-1:0];
	assign s_step   = s_tdata[sosmet_pkg::IN_STEP_BIT];
	assign s_draw   = s_tdata[sosmet_pkg::IN_DRAW_LSB +: sosmet_pkg::DRAW_W];
	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// ring geometry
	always_comb begin
		w_eff    = (CW'(lattice_width_q) > CW'(MAX_SITES)) ? CW'(MAX_SITES) : CW'(lattice_width_q);
		site_ext = CW'(s_site);
		site_inc = site_ext + CW'(1);
		in_ring  = site_ext < w_eff;
		right_c  = (site_inc == w_eff) ? '0 : site_inc;
		left_c   = (site_ext == '0) ? w_eff - CW'(1) : site_ext - CW'(1);
	end

	// height evaluation
	always_comb begin
		ref_s    = DW'(ref_height_q);
		refc_s   = (ref_s > HMAX_S) ? HMAX_S : ref_s;
		upper_s  = ((ref_s + ref_s) > HMAX_S) ? HMAX_S : (ref_s + ref_s);
		refc_h   = refc_s[HB-1:0];
		hr_h     = hval(ram_rdata, refc_h);
		hx_s     = DW'(hx_q);
		hl_s     = DW'(hl_q);
		hr_s     = DW'(hr_h);
		hn_s     = step_q ? hx_s + ONE_S : hx_s - ONE_S;
		ev_ok    = (hn_s >= 0) && (hn_s <= upper_s);
		ev_fpos  = absd(ref_s - hn_s) > absd(ref_s - hx_s);
		span_new = absd(hn_s - hl_s) + absd(hn_s - hr_s);
		span_old = absd(hx_s - hl_s) + absd(hx_s - hr_s);
		if (span_new < span_old) begin
			ev_sos = 2'd0;
		end else if (span_new == span_old) begin
			ev_sos = 2'd1;
		end else begin
			ev_sos = 2'd2;
		end
	end

	assign thr_sel  = thr_q[tsel_q];
	assign dec_acc  = ok_q && ({1'b0, draw_q} < thr_sel);
	assign out_free = !m_tvalid_q || m_tready;

	// memory port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = site_q;
		ram_wdata = {1'b1, hn_q};
		ram_raddr = AW'(site_ext);
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_cnt_q;
				ram_wdata = '0;
			end
			S_RDL: ram_raddr = left_q;
			S_RDR: ram_raddr = right_q;
			S_DEC: ram_we    = dec_acc;
			default: ;
		endcase
	end

	always_comb begin
		acc_ctl        = '0;
		acc_ctl.clr    = s_accept && s_cmd;
		acc_ctl.apply  = (state_q == S_DEC) && dec_acc;
		acc_ctl.f_pos  = fpos_q;
		acc_ctl.square = (state_q == S_SQ);
		acc_ctl.add    = (state_q == S_ADD);
	end

	sosmet_height_ram #(
		.DEPTH  (MAX_SITES),
		.ADDR_W (AW),
		.DATA_W (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	sosmet_accum u_accum (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (acc_ctl),
		.order_acc     (order_acc),
		.order_total   (order_total),
		.order_squares (order_squares)
	);

	// configuration registers
	assign cfg_thr_idx = cfg_idx - sosmet_pkg::THR_IDX_W'(sosmet_pkg::REG_THR_FIRST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lattice_width_q <= sosmet_pkg::LW_W'(70);
			ref_height_q    <= sosmet_pkg::REF_W'(30);
			thr_q[0]        <= 33'h1_0000_0000;
			thr_q[1]        <= 33'h1_0000_0000;
			thr_q[2]        <= 33'h1_0000_0000;
			thr_q[3]        <= 33'h1_0000_0000;
			thr_q[4]        <= 33'd1779033703;
			thr_q[5]        <= 33'd1779033703;
		end else if (cfg_we) begin
			case (cfg_idx)
				sosmet_pkg::CFG_IDX_W'(sosmet_pkg::REG_LATTICE_WIDTH):
					lattice_width_q <= cfg_data[sosmet_pkg::LW_W-1:0];
				sosmet_pkg::CFG_IDX_W'(sosmet_pkg::REG_REF_HEIGHT):
					ref_height_q <= cfg_data[sosmet_pkg::REF_W-1:0];
				default: thr_q[cfg_thr_idx] <= cfg_data;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_cnt_q  <= '0;
			reinit_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					if (clr_cnt_q == AW'(MAX_SITES - 1)) begin
						clr_cnt_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (s_accept) begin
						reinit_q <= s_cmd;
						state_q  <= (s_cmd || !in_ring) ? S_DONE : S_RDL;
					end
				end
				S_RDL:  state_q <= S_RDR;
				S_RDR:  state_q <= S_EVAL;
				S_EVAL: state_q <= S_DEC;
				S_DEC:  state_q <= S_SQ;
				S_SQ:   state_q <= S_ADD;
				S_ADD:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= reinit_q ? S_CLEAR : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				site_q    <= AW'(site_ext);
				left_q    <= AW'(left_c);
				right_q   <= AW'(right_c);
				step_q    <= s_step;
				draw_q    <= s_draw << RSH;
				res_acc_q <= 1'b0;
				res_h_q   <= '0;
			end
			S_RDL: hx_q <= hval(ram_rdata, refc_h);
			S_RDR: hl_q <= hval(ram_rdata, refc_h);
			S_EVAL: begin
				ok_q   <= ev_ok;
				fpos_q <= ev_fpos;
				tsel_q <= {ev_sos, ev_fpos};
				hn_q   <= hn_s[HB-1:0];
			end
			S_DEC: begin
				res_acc_q <= dec_acc;
				res_h_q   <= dec_acc ? hn_q : hx_q;
			end
			S_DONE: begin
				if (out_free) begin
					out_acc_q <= res_acc_q;
					out_h_q   <= sosmet_pkg::OUT_H_W'(res_h_q);
					out_op_q  <= order_acc;
					out_sum_q <= order_total;
					out_sq_q  <= order_squares;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{sosmet_pkg::OUT_PAD_W{1'b0}}, out_sq_q, out_sum_q, out_op_q,
	                   out_h_q, out_acc_q};

	assign res_h_in_range = (DW'(res_h_q) <= upper_s);

	// an applied move never leaves the legal height band
	`SOS_ASSERT_IMPL(a_acc_height_in_band, clk, arst_n, (state_q == S_DONE) && res_acc_q, res_h_in_range)
	// reinit zeroes every accumulator on the next edge
	`SOS_ASSERT_NEXT(a_reinit_clears_sums, clk, arst_n, s_accept && s_cmd, (order_acc == 0) && (order_total == 0) && (order_squares == 0))
	// a valid height entry is written only by an accepted move
	`SOS_ASSERT_IMPL(a_valid_write_on_move, clk, arst_n, ram_we && ram_wdata[HB], (state_q == S_DEC) && dec_acc)

endmodule
